### design/reload_timer_with_prescaler_macros.svh
// assertion macros shared by the reload timer modules
`ifndef RELOAD_TIMER_WITH_PRESCALER_MACROS_SVH
`define RELOAD_TIMER_WITH_PRESCALER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define RTWP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define RTWP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rtwp_pkg.sv
// types and constants for the reload timer with prescaler
package rtwp_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int FREE_WIDTH  = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int CFG_IDX_WIDTH = 2;

    // request types
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // register addresses
    localparam logic [2:0] ADDR_COUNT   = 3'd0;
    localparam logic [2:0] ADDR_RELOAD  = 3'd1;
    localparam logic [2:0] ADDR_CONTROL = 3'd2;
    localparam logic [2:0] ADDR_FREE_LO = 3'd3;
    localparam logic [2:0] ADDR_FREE_HI = 3'd4;

    // control word bit positions
    localparam int CTL_ENABLE_BIT  = 0;
    localparam int CTL_RESTART_BIT = 1;
    localparam int CTL_IRQ_EN_BIT  = 2;
    localparam int CTL_PENDING_BIT = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRESCALER_ON    = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRESCALE_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FREE_COUNTER_ON = 2'd2;

    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_WIDTH-1:0] index;
        logic [DATA_WIDTH-1:0]    data;
    } t_cfg_wr;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [2:0]            reg_addr;
        logic [DATA_WIDTH-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic [COUNT_WIDTH-1:0] reload;
        logic                   enabled;
        logic                   restart;
        logic                   irq_en;
        logic                   pending;
    } t_timer_regs;

endpackage

### design/reload_timer_with_prescaler.sv
// Reload timer with prescaler: a register-mapped down counter driven by raw clock ticks.
// Each transaction is a raw tick, a register read or a register write and yields exactly
// one result (read data, zero for ticks and writes, plus the interrupt line after the
// item). Throughput is one transaction per cycle unless the output stalls; the input
// register feeds the result register, with all state updated in the cycle between them.
// The result register decouples the two sides, so a new transaction is taken while a
// finished one waits. Timer state clears on reset with no clearing pass. Write
// configuration (prescaler on, divisor, free counter on) only while idle; not enforced.
`include "reload_timer_with_prescaler_macros.svh"

module reload_timer_with_prescaler (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rtwp_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [rtwp_pkg::DATA_WIDTH-1:0]       i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_req_type,
    input  logic [2:0]                            i_reg_addr,
    input  logic [rtwp_pkg::DATA_WIDTH-1:0]       i_write_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [rtwp_pkg::DATA_WIDTH-1:0]       o_read_data,
    output logic                                  o_irq_line
);

    rtwp_pkg::t_cfg_wr                  cfg;
    rtwp_pkg::t_item                    r_item;
    rtwp_pkg::t_timer_regs              timer_regs;
    logic                               r_in_valid;
    logic                               r_out_valid;
    logic [rtwp_pkg::DATA_WIDTH-1:0]    r_read_data;
    logic [rtwp_pkg::DATA_WIDTH-1:0]    n_read_data;
    logic                               r_irq;
    logic                               irq_next;
    logic                               exec;
    logic                               in_accept;
    logic                               timer_tick;
    logic [rtwp_pkg::FREE_WIDTH-1:0]    free_count;
    logic [63:0]                        free_ext;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_wdata;

    // the held transaction executes when the result register is free or being drained
    assign exec       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec;
    assign in_accept  = i_in_valid && !o_in_stall;

    rtwp_tick u_tick (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_tick_exec  (exec && r_item.req_type == rtwp_pkg::REQ_TICK),
        .o_timer_tick (timer_tick),
        .o_free_count (free_count)
    );

    rtwp_timer u_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_exec       (exec),
        .i_item       (r_item),
        .i_timer_tick (timer_tick),
        .o_regs       (timer_regs),
        .o_irq_next   (irq_next)
    );

    assign free_ext = 64'(free_count);

    always_comb begin
        n_read_data = '0;
        if (r_item.req_type == rtwp_pkg::REQ_READ) begin
            case (r_item.reg_addr)
                rtwp_pkg::ADDR_COUNT: begin
                    n_read_data = rtwp_pkg::DATA_WIDTH'(timer_regs.count);
                end
                rtwp_pkg::ADDR_RELOAD: begin
                    n_read_data = rtwp_pkg::DATA_WIDTH'(timer_regs.reload);
                end
                rtwp_pkg::ADDR_CONTROL: begin
                    n_read_data[rtwp_pkg::CTL_ENABLE_BIT]  = timer_regs.enabled;
                    n_read_data[rtwp_pkg::CTL_RESTART_BIT] = timer_regs.restart;
                    n_read_data[rtwp_pkg::CTL_IRQ_EN_BIT]  = timer_regs.irq_en;
                    n_read_data[rtwp_pkg::CTL_PENDING_BIT] = timer_regs.pending;
                end
                rtwp_pkg::ADDR_FREE_LO: begin
                    n_read_data = free_ext[31:0];
                end
                rtwp_pkg::ADDR_FREE_HI: begin
                    n_read_data = free_ext[63:32];
                end
                default: begin
                    n_read_data = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (exec) begin
                r_in_valid <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.req_type   <= i_req_type;
            r_item.reg_addr   <= i_reg_addr;
            r_item.write_data <= i_write_data;
        end
        if (exec) begin
            r_read_data <= n_read_data;
            r_irq       <= irq_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_irq_line  = r_irq;

    `RTWP_ASSERT_NEXT(a_exec_fills_result, exec, r_out_valid,
        "executed transaction produced no result")
    `RTWP_ASSERT_SAME(a_stall_only_when_full, o_in_stall,
        r_in_valid && r_out_valid && i_out_stall,
        "input stalled while the pipeline could advance")

endmodule

### design/rtwp_tick.sv
// prescaler, free-running tick counter and configuration registers
`include "reload_timer_with_prescaler_macros.svh"

module rtwp_tick (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rtwp_pkg::t_cfg_wr               i_cfg,
    input  logic                            i_tick_exec,
    output logic                            o_timer_tick,
    output logic [rtwp_pkg::FREE_WIDTH-1:0] o_free_count
);

    logic                               r_prescaler_on;
    logic [rtwp_pkg::DATA_WIDTH-1:0]    r_divisor;
    logic                               r_free_on;
    logic [rtwp_pkg::DATA_WIDTH-1:0]    r_prescale_count;
    logic [rtwp_pkg::DATA_WIDTH-1:0]    n_prescale_count;
    logic [rtwp_pkg::FREE_WIDTH-1:0]    r_free_count;
    logic [rtwp_pkg::FREE_WIDTH-1:0]    n_free_count;
    logic                               prescale_hit;

    // compare is >= so a lowered divisor fires on the next raw tick
    assign prescale_hit = r_prescale_count >= r_divisor;
    assign o_timer_tick = i_tick_exec && r_prescaler_on && prescale_hit;
    assign o_free_count = r_free_count;

    always_comb begin
        n_prescale_count = r_prescale_count;
        n_free_count     = r_free_count;
        if (i_tick_exec) begin
            if (r_free_on) begin
                n_free_count = r_free_count + 1'b1;
            end
            if (r_prescaler_on) begin
                if (prescale_hit) begin
                    n_prescale_count = '0;
                end else begin
                    n_prescale_count = r_prescale_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescaler_on   <= 1'b0;
            r_divisor        <= '0;
            r_free_on        <= 1'b0;
            r_prescale_count <= '0;
            r_free_count     <= '0;
        end else begin
            r_prescale_count <= n_prescale_count;
            r_free_count     <= n_free_count;
            if (i_cfg.we) begin
                case (i_cfg.index)
                    rtwp_pkg::CFG_PRESCALER_ON: begin
                        r_prescaler_on <= i_cfg.data[0];
                    end
                    rtwp_pkg::CFG_PRESCALE_DIVISOR: begin
                        r_divisor <= i_cfg.data;
                    end
                    rtwp_pkg::CFG_FREE_COUNTER_ON: begin
                        r_free_on <= i_cfg.data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    `RTWP_ASSERT_NEXT(a_prescale_hold_when_off, !r_prescaler_on, $stable(r_prescale_count),
        "prescale count moved while prescaler off")
    `RTWP_ASSERT_NEXT(a_free_hold_when_off, !r_free_on, $stable(r_free_count),
        "free counter moved while disabled")

endmodule

### design/rtwp_timer.sv
// down counter, reload value and control/status bits
`include "reload_timer_with_prescaler_macros.svh"

module rtwp_timer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_exec,
    input  rtwp_pkg::t_item       i_item,
    input  logic                  i_timer_tick,
    output rtwp_pkg::t_timer_regs o_regs,
    output logic                  o_irq_next
);

    rtwp_pkg::t_timer_regs r_regs;
    rtwp_pkg::t_timer_regs n_regs;

    assign o_regs     = r_regs;
    assign o_irq_next = n_regs.pending && n_regs.irq_en;

    always_comb begin
        n_regs = r_regs;
        if (i_timer_tick && r_regs.enabled) begin
            if (r_regs.count > rtwp_pkg::COUNT_WIDTH'(1)) begin
                n_regs.count = r_regs.count - 1'b1;
            end else begin
                n_regs.pending = 1'b1;
                if (r_regs.restart) begin
                    n_regs.count = r_regs.reload;
                end else begin
                    n_regs.count   = '0;
                    n_regs.enabled = 1'b0;
                end
            end
        end else if (i_exec && i_item.req_type == rtwp_pkg::REQ_WRITE) begin
            case (i_item.reg_addr)
                rtwp_pkg::ADDR_COUNT: begin
                    n_regs.count = i_item.write_data[rtwp_pkg::COUNT_WIDTH-1:0];
                end
                rtwp_pkg::ADDR_RELOAD: begin
                    n_regs.reload = i_item.write_data[rtwp_pkg::COUNT_WIDTH-1:0];
                end
                rtwp_pkg::ADDR_CONTROL: begin
                    n_regs.enabled = i_item.write_data[rtwp_pkg::CTL_ENABLE_BIT];
                    n_regs.restart = i_item.write_data[rtwp_pkg::CTL_RESTART_BIT];
                    n_regs.irq_en  = i_item.write_data[rtwp_pkg::CTL_IRQ_EN_BIT];
                    // pending is write-zero-to-clear
                    if (!i_item.write_data[rtwp_pkg::CTL_PENDING_BIT]) begin
                        n_regs.pending = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else begin
            r_regs <= n_regs;
        end
    end

    `RTWP_ASSERT_NEXT(a_one_shot_expiry,
        i_timer_tick && r_regs.enabled && !r_regs.restart
            && r_regs.count <= rtwp_pkg::COUNT_WIDTH'(1),
        !r_regs.enabled && r_regs.pending && r_regs.count == '0,
        "one-shot expiry did not stop the timer")
    `RTWP_ASSERT_NEXT(a_read_no_side_effect,
        i_exec && i_item.req_type == rtwp_pkg::REQ_READ,
        $stable(r_regs),
        "register read changed timer state")

endmodule
